// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Result status codes
  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // Command codes
  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  // Broadcast to every cell in the chain for one accepted item
  typedef struct packed {
    logic              push;   // insert value (queue not full)
    logic              pop;    // remove head (queue not empty)
    logic signed [7:0] value;
  } spq_ctl_t;

endpackage

`default_nettype wire

// File: rtl/spq_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one push or pop command per item
interface spq_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [7:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Result channel: queue state after each item
interface spq_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] head_value;
  logic [4:0]        entry_count;
  logic              is_empty;
  logic [1:0]        status;

  modport source (output valid, output head_value, output entry_count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input head_value, input entry_count,
                  input is_empty, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted chain. Lower index holds the smaller value.
module spq_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spq_pkg::spq_ctl_t ctl_i,
  // left neighbor (smaller side)
  input  wire logic              left_vld_i,
  input  wire logic signed [7:0] left_val_i,
  input  wire logic              left_le_i,
  // right neighbor (larger side)
  input  wire logic              right_vld_i,
  input  wire logic signed [7:0] right_val_i,
  // own state, seen by neighbors
  output logic                   vld_o,
  output logic signed [7:0]      val_o,
  output logic                   le_o
);
  import spq_pkg::*;

  logic              vld_q, vld_d;
  logic signed [7:0] val_q, val_d;

  // Entry stays in place on push when it is <= the new value (stable order)
  assign le_o  = vld_q && (val_q <= ctl_i.value);
  assign vld_o = vld_q;
  assign val_o = val_q;

  // Next-state: keep, take new value, shift right, or shift left
  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctl_i.push) begin
      if (!le_o) begin
        vld_d = vld_q | left_vld_i;
        if (left_le_i) begin
          val_d = ctl_i.value;
        end else begin
          val_d = left_val_i;
        end
      end
    end else if (ctl_i.pop) begin
      vld_d = right_vld_i;
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset; valid bit guards it
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// File: rtl/sorted_min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded min priority queue kept as a sorted chain of DEPTH cells.
// in_i carries a command (0 push value, 1 pop smallest) and a signed value.
// res_o returns one item per command: head value after the operation (zero
// when empty), entry count (low 5 bits), empty flag and status (done, push
// dropped because full, pop on empty ignored).
// Every cell compares its entry with the pushed value in parallel and either
// holds, takes the new value, or takes its neighbor's entry, so one command
// completes in the cycle it is accepted. The result is valid in the cycle after
// acceptance; throughput is one item per cycle while the receiver does not stall,
// set by the single output register. in_i.ready is high whenever that register
// is empty or is being read, so a stalled receiver holds the result and stops
// input intake. Reset clears all cell valid bits and the count: the queue comes
// up empty, with no clearing pass. Equal values leave in arrival order.
module sorted_min_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  res_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic              cell_vld [DEPTH];
  logic signed [7:0] cell_val [DEPTH];
  logic              cell_le  [DEPTH];

  logic              accept;
  logic              full, empty;
  spq_ctl_t          ctl;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        status_d;

  logic              out_vld_q;
  logic [1:0]        status_q;

  assign in_i.ready = !out_vld_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = cell_vld[DEPTH-1];
  assign empty      = !cell_vld[0];

  // Command decode, broadcast to all cells
  always_comb begin
    ctl.value = in_i.value;
    ctl.push  = accept && (in_i.cmd == CmdPush) && !full;
    ctl.pop   = accept && (in_i.cmd == CmdPop) && !empty;
    cnt_d     = cnt_q;
    status_d  = StDone;
    if (ctl.push) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctl.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
    if (in_i.cmd == CmdPush) begin
      if (full) status_d = StFull;
    end else begin
      if (empty) status_d = StEmpty;
    end
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              l_vld, l_le, r_vld;
    logic signed [7:0] l_val, r_val;

    if (i == 0) begin : g_first
      assign l_vld = 1'b1;
      assign l_val = in_i.value;
      assign l_le  = 1'b1;
    end else begin : g_mid
      assign l_vld = cell_vld[i-1];
      assign l_val = cell_val[i-1];
      assign l_le  = cell_le[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_vld = 1'b0;
      assign r_val = '0;
    end else begin : g_rest
      assign r_vld = cell_vld[i+1];
      assign r_val = cell_val[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_vld_i  (l_vld),
      .left_val_i  (l_val),
      .left_le_i   (l_le),
      .right_vld_i (r_vld),
      .right_val_i (r_val),
      .vld_o       (cell_vld[i]),
      .val_o       (cell_val[i]),
      .le_o        (cell_le[i])
    );
  end

  // Count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  // Cells and count only change on accept, which cannot happen while the
  // result is held, so head and count are read straight from state
  assign res_o.valid       = out_vld_q;
  assign res_o.head_value  = cell_vld[0] ? cell_val[0] : 8'sd0;
  assign res_o.entry_count = 5'(cnt_q);
  assign res_o.is_empty    = !cell_vld[0];
  assign res_o.status      = status_q;

endmodule

`default_nettype wire

// File: rtl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_checker #(
  parameter int DEPTH = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  head_value_i,
  input wire logic [4:0]  entry_count_i,
  input wire logic        is_empty_i,
  input wire logic [1:0]  status_i
);
  import spq_pkg::*;

  localparam logic [4:0] FullCnt = 5'(DEPTH);

  // Empty flag agrees with the count (DEPTH below 32)
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (DEPTH < 32) |-> (is_empty_i == (entry_count_i == 5'd0)))
    else $error("is_empty disagrees with entry_count");

  // An ignored pop leaves an empty queue with zero head
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == StEmpty) |-> is_empty_i && (head_value_i == 8'd0))
    else $error("empty status on non-empty queue");

  // A dropped push reports a full queue
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == StFull) |-> !is_empty_i && (entry_count_i == FullCnt))
    else $error("full status on non-full queue");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(head_value_i) &&
      $stable(entry_count_i) && $stable(status_i))
    else $error("result changed while stalled");

endmodule

bind sorted_min_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .head_value_i  (res_o.head_value),
  .entry_count_i (res_o.entry_count),
  .is_empty_i    (res_o.is_empty),
  .status_i      (res_o.status)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import spq_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int RAND_ITEMS = 1130;
  localparam int CALM_ITEMS = 150;    // tail of the run without idling
  localparam int QUIET_MAX  = 2000;   // cycles with no item moving on either side

  // Queue view reported after one command
  typedef struct {
    logic signed [7:0] head;
    logic [4:0]        count;
    logic              empty;
    logic [1:0]        status;
  } queue_view_t;

  // One line of the directed script
  typedef struct {
    logic              cmd;
    logic signed [7:0] val;
    int                reps;
    bit                typed;
    queue_view_t       view;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  in_ch ();
  spq_out_if res_ch ();

  sorted_min_priority_queue #(.DEPTH(QDEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .res_o (res_ch)
  );

  // Predictor state: stored values in ascending order
  logic signed [7:0] held_vals[$];
  queue_view_t       pending_views[$];
  script_row_t       script[10];

  int idle_pct   = 10;
  int stall_left = 0;
  int quiet_cnt  = 0;
  bit failed     = 1'b0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Apply one command to the predicted queue and return the view after it
  function automatic queue_view_t queue_step(input logic cmd, input logic signed [7:0] val);
    queue_view_t v;
    int pos;
    v.status = StDone;
    pos = 0;
    if (cmd == CmdPush) begin
      if (held_vals.size() >= QDEPTH) begin
        v.status = StFull;
      end else begin
        // equal values stay behind earlier ones
        while (pos < held_vals.size() && held_vals[pos] <= val) pos++;
        held_vals.insert(pos, val);
      end
    end else begin
      if (held_vals.size() == 0) v.status = StEmpty;
      else held_vals.delete(0);
    end
    v.head  = (held_vals.size() > 0) ? held_vals[0] : 8'sd0;
    v.count = 5'(held_vals.size());
    v.empty = (held_vals.size() == 0);
    return v;
  endfunction

  // Offer one command, wait for it to be taken, record what it should return.
  // Entered and left at a falling edge.
  task automatic send_cmd(input logic cmd, input logic signed [7:0] val,
                          input bit typed, input queue_view_t typed_view);
    queue_view_t v;
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    v = queue_step(cmd, val);
    pending_views.insert(pending_views.size(), typed ? typed_view : v);
    @(negedge clk_i);
  endtask

  // Receiver stalls in bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      stall_left   <= 0;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left   <= $urandom_range(0, 11);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    queue_view_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_views.size() == 0) begin
        $error("result item with nothing expected");
        failed = 1'b1;
      end else begin
        want = pending_views[0];
        pending_views.delete(0);
        if (res_ch.head_value !== want.head) begin
          $error("head_value: expected %0d, got %0d", want.head, res_ch.head_value);
          failed = 1'b1;
        end
        if (res_ch.entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, res_ch.entry_count);
          failed = 1'b1;
        end
        if (res_ch.is_empty !== want.empty) begin
          $error("is_empty: expected %0d, got %0d", want.empty, res_ch.is_empty);
          failed = 1'b1;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cnt <= 0;
      else quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= QUIET_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    queue_view_t no_view;
    int sent;
    int seg_len;
    int push_pct;
    bit narrow;
    logic cmd;
    logic signed [7:0] val;

    no_view      = '{8'sd0, 5'd0, 1'b0, StDone};
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CmdPush;
    in_ch.value  = 8'sd0;

    // empty pop, extremes, equal values, fill to full, push when full, drain a few
    script[0] = '{CmdPop,  8'sd0,   1,  1'b1, '{8'sd0,   5'd0,  1'b1, StEmpty}};
    script[1] = '{CmdPush, 8'sd127, 1,  1'b1, '{8'sd127, 5'd1,  1'b0, StDone}};
    script[2] = '{CmdPush, 8'sh80,  1,  1'b1, '{8'sh80,  5'd2,  1'b0, StDone}};
    script[3] = '{CmdPush, 8'sh80,  1,  1'b0, no_view};
    script[4] = '{CmdPush, 8'sd0,   1,  1'b0, no_view};
    script[5] = '{CmdPop,  8'shFF,  1,  1'b0, no_view};
    script[6] = '{CmdPush, 8'sd1,   13, 1'b0, no_view};
    script[7] = '{CmdPush, 8'shFF,  1,  1'b1, '{8'sh80,  5'd16, 1'b0, StFull}};
    script[8] = '{CmdPush, 8'sd127, 1,  1'b0, no_view};
    script[9] = '{CmdPop,  8'sd0,   3,  1'b0, no_view};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[r]) begin
      repeat (script[r].reps) send_cmd(script[r].cmd, script[r].val,
                                       script[r].typed, script[r].view);
    end

    // Random part: segments that lean toward filling, draining or churning
    sent = 0;
    while (sent < RAND_ITEMS) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      narrow = ($urandom_range(0, 2) == 0);
      if (sent >= RAND_ITEMS - CALM_ITEMS) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 8;
          default: idle_pct = 25;
        endcase
      end
      repeat (seg_len) begin
        if (sent < RAND_ITEMS) begin
          cmd = ($urandom_range(0, 99) < push_pct) ? CmdPush : CmdPop;
          // narrow values give many ties
          if (narrow) val = 8'($signed($urandom_range(0, 4)) - 2);
          else        val = 8'($urandom_range(0, 255));
          send_cmd(cmd, val, 1'b0, no_view);
          sent++;
        end
      end
    end
    in_ch.valid <= 1'b0;
    idle_pct = 0;

    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_min_priority_queue.sv
rtl/spq_checker.sv
verif/tb.sv
